// ----- rtl/core/clipped_sprite_blitter_macros.svh -----
// Assertion macros used by the sprite blitter datapath.
`ifndef CLIPPED_SPRITE_BLITTER_MACROS_SVH
`define CLIPPED_SPRITE_BLITTER_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define CSB_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define CSB_ASSERT_NXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/csb_pkg.sv -----
// Shared constants, types and codes of the clipped sprite blitter.
package csb_pkg;

   localparam int MAX_CELL_W = 8;
   localparam int MAX_CELL_H = 8;
   localparam int STORE_AW   = 14;
   localparam int STORE_DEPTH = 1 << STORE_AW;
   localparam int CW_W = $clog2(MAX_CELL_W + 1);
   localparam int CH_W = $clog2(MAX_CELL_H + 1);
   localparam int CELL_IDX_W = 8;

   localparam logic [10:0] CLIP_MAX_RESET  = 11'd256;
   localparam logic [3:0]  CELL_SIZE_RESET = 4'd8;

   typedef enum logic [2:0] {
      CSR_OFFSET_X,
      CSR_OFFSET_Y,
      CSR_CLIP_MIN_X,
      CSR_CLIP_MIN_Y,
      CSR_CLIP_MAX_X,
      CSR_CLIP_MAX_Y,
      CSR_CELL_WIDTH,
      CSR_CELL_HEIGHT
   } csr_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_OFFS,
      S_CLIP,
      S_ADDR,
      S_RUN,
      S_BLANK
   } state_type;

   typedef struct packed {
      logic load_write;
      logic capture;
      logic step_offs;
      logic step_clip;
      logic step_addr;
      logic issue_pixel;
      logic issue_blank;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic a_ready;
      logic last_pix;
   } sts_type;

endpackage

// ----- rtl/core/csb_ctrl.sv -----
// Controller state machine: sequences setup steps and the pixel walk.
module csb_ctrl import csb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   input  logic    req_kind,
   output logic    req_tready,
   output cmd_type cmd,
   input  sts_type sts
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_kind) begin
                  cmd.capture = 1'b1;
                  state_in    = S_OFFS;
               end else begin
                  cmd.load_write = 1'b1;
               end
            end
         end
         S_OFFS: begin
            cmd.step_offs = 1'b1;
            state_in      = S_CLIP;
         end
         S_CLIP: begin
            cmd.step_clip = 1'b1;
            state_in      = S_ADDR;
         end
         S_ADDR: begin
            if (sts.empty) begin
               state_in = S_BLANK;
            end else begin
               cmd.step_addr = 1'b1;
               state_in      = S_RUN;
            end
         end
         S_RUN: begin
            if (sts.a_ready) begin
               cmd.issue_pixel = 1'b1;
               if (sts.last_pix) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_BLANK: begin
            if (sts.a_ready) begin
               cmd.issue_blank = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/core/csb_datapath.sv -----
// Datapath: config registers, sprite store, clipping, pixel walk and output stages.
`include "clipped_sprite_blitter_macros.svh"
module csb_datapath import csb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic [71:0] req_tdata,
   input  cmd_type     cmd,
   output sts_type     sts,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,
   output logic        rsp_tlast
);

   // configuration
   logic signed [15:0] offset_x_ff, offset_y_ff;
   logic [9:0]         clip_min_x_ff, clip_min_y_ff;
   logic [10:0]        clip_max_x_ff, clip_max_y_ff;
   logic [3:0]         cell_width_ff, cell_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_x_ff    <= '0;
         offset_y_ff    <= '0;
         clip_min_x_ff  <= '0;
         clip_min_y_ff  <= '0;
         clip_max_x_ff  <= CLIP_MAX_RESET;
         clip_max_y_ff  <= CLIP_MAX_RESET;
         cell_width_ff  <= CELL_SIZE_RESET;
         cell_height_ff <= CELL_SIZE_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_OFFSET_X:    offset_x_ff    <= csr_wdata;
            CSR_OFFSET_Y:    offset_y_ff    <= csr_wdata;
            CSR_CLIP_MIN_X:  clip_min_x_ff  <= csr_wdata[9:0];
            CSR_CLIP_MIN_Y:  clip_min_y_ff  <= csr_wdata[9:0];
            CSR_CLIP_MAX_X:  clip_max_x_ff  <= csr_wdata[10:0];
            CSR_CLIP_MAX_Y:  clip_max_y_ff  <= csr_wdata[10:0];
            CSR_CELL_WIDTH:  cell_width_ff  <= csr_wdata[3:0];
            CSR_CELL_HEIGHT: cell_height_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // input fields
   logic signed [15:0]    in_pos_x, in_pos_y;
   logic [CELL_IDX_W-1:0] in_cell_index;
   logic                  in_flip, in_mask;
   logic [7:0]            in_mask_color, in_load_value;
   logic [STORE_AW-1:0]   in_load_address;

   assign in_pos_x        = req_tdata[15:0];
   assign in_pos_y        = req_tdata[31:16];
   assign in_cell_index   = req_tdata[39:32];
   assign in_flip         = req_tdata[40];
   assign in_mask         = req_tdata[41];
   assign in_mask_color   = req_tdata[49:42];
   assign in_load_address = req_tdata[63:50];
   assign in_load_value   = req_tdata[71:64];

   // sprite store
   logic [7:0] store [STORE_DEPTH];
   logic [STORE_AW-1:0] read_addr;
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_write) begin
         store[in_load_address] <= in_load_value;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue_pixel) begin
         rd_data_ff <= store[read_addr];
      end
   end

   // captured draw item
   logic signed [15:0]    pos_x_ff, pos_y_ff;
   logic [CELL_IDX_W-1:0] idx_ff;
   logic                  flip_ff, mask_ff;
   logic [7:0]            mcol_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         pos_x_ff <= in_pos_x;
         pos_y_ff <= in_pos_y;
         idx_ff   <= in_cell_index;
         flip_ff  <= in_flip;
         mask_ff  <= in_mask;
         mcol_ff  <= in_mask_color;
      end
   end

   // saturated cell size
   logic [CW_W-1:0] cw_sat;
   logic [CH_W-1:0] ch_sat;

   assign cw_sat = (cell_width_ff > 4'(MAX_CELL_W)) ? CW_W'(MAX_CELL_W) : CW_W'(cell_width_ff);
   assign ch_sat = (cell_height_ff > 4'(MAX_CELL_H)) ? CH_W'(MAX_CELL_H)
                                                     : CH_W'(cell_height_ff);

   // offset step
   logic signed [17:0]   rx0_ff, ry0_ff;
   logic [CW_W+CH_W-1:0] cwh_ff;

   always_ff @(posedge clock) begin
      if (cmd.step_offs) begin
         rx0_ff <= 18'(pos_x_ff) + 18'(offset_x_ff);
         ry0_ff <= 18'(pos_y_ff) + 18'(offset_y_ff);
         cwh_ff <= (CW_W+CH_W)'(cw_sat) * (CW_W+CH_W)'(ch_sat);
      end
   end

   // clip step
   logic signed [17:0] cw_c, ch_c, rx1_c, ry1_c, cx0_c, cy0_c, cx1_c, cy1_c;
   logic signed [17:0] lx_c, hx_c, ly_c, hy_c, dx_c, dy_c, ux_c, vy_c;
   logic signed [17:0] lx_ff, ly_ff;
   logic [CW_W-1:0]    ncols_ff, u0_ff;
   logic [CH_W-1:0]    nrows_ff, v0_ff;
   logic [1:0]         status_ff;
   logic               empty_ff;
   logic [STORE_AW-1:0] base_ff;

   always_comb begin
      cw_c  = 18'(cw_sat);
      ch_c  = 18'(ch_sat);
      cx0_c = 18'(clip_min_x_ff);
      cy0_c = 18'(clip_min_y_ff);
      cx1_c = 18'(clip_max_x_ff);
      cy1_c = 18'(clip_max_y_ff);
      rx1_c = rx0_ff + cw_c;
      ry1_c = ry0_ff + ch_c;
      lx_c  = (rx0_ff > cx0_c) ? rx0_ff : cx0_c;
      ly_c  = (ry0_ff > cy0_c) ? ry0_ff : cy0_c;
      hx_c  = (rx1_c < cx1_c) ? rx1_c : cx1_c;
      hy_c  = (ry1_c < cy1_c) ? ry1_c : cy1_c;
      dx_c  = hx_c - lx_c;
      dy_c  = hy_c - ly_c;
      ux_c  = lx_c - rx0_ff;
      vy_c  = ly_c - ry0_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.step_clip) begin
         lx_ff     <= lx_c;
         ly_ff     <= ly_c;
         ncols_ff  <= dx_c[CW_W-1:0];
         nrows_ff  <= dy_c[CH_W-1:0];
         u0_ff     <= ux_c[CW_W-1:0];
         v0_ff     <= vy_c[CH_W-1:0];
         empty_ff  <= (lx_c >= hx_c) || (ly_c >= hy_c);
         status_ff <= (lx_c != rx0_ff || hx_c != rx1_c || ly_c != ry0_ff || hy_c != ry1_c)
                      ? 2'd2 : 2'd1;
         base_ff   <= STORE_AW'(CELL_IDX_W'(idx_ff) * (CELL_IDX_W+CW_W+CH_W)'(cwh_ff));
      end
   end

   // address step and pixel walk
   logic [21:0]         row_prod_c, row_pix_c;
   logic [CW_W-1:0]     scol_c;
   logic [CW_W-1:0]     src_col_ff, scol_start_ff, col_rem_ff;
   logic [CH_W-1:0]     row_rem_ff;
   logic [STORE_AW-1:0] row_base_ff;
   logic [19:0]         pix_ff, row_pix_ff;
   logic                last_col;

   assign row_prod_c = 22'(ly_ff[10:0]) * 22'(clip_max_x_ff);
   assign row_pix_c  = row_prod_c + 22'(lx_ff[10:0]);
   assign scol_c     = flip_ff ? (cw_sat - CW_W'(1) - u0_ff) : u0_ff;
   assign read_addr  = row_base_ff + STORE_AW'(src_col_ff);
   assign last_col   = (col_rem_ff == CW_W'(1));

   always_ff @(posedge clock) begin
      if (cmd.step_addr) begin
         row_base_ff   <= base_ff + STORE_AW'((CW_W+CH_W)'(v0_ff) * (CW_W+CH_W)'(cw_sat));
         src_col_ff    <= scol_c;
         scol_start_ff <= scol_c;
         pix_ff        <= row_pix_c[19:0];
         row_pix_ff    <= row_pix_c[19:0];
         col_rem_ff    <= ncols_ff;
         row_rem_ff    <= nrows_ff;
      end else if (cmd.issue_pixel) begin
         if (last_col) begin
            col_rem_ff  <= ncols_ff;
            row_rem_ff  <= row_rem_ff - CH_W'(1);
            row_base_ff <= row_base_ff + STORE_AW'(cw_sat);
            src_col_ff  <= scol_start_ff;
            row_pix_ff  <= row_pix_ff + 20'(clip_max_x_ff);
            pix_ff      <= row_pix_ff + 20'(clip_max_x_ff);
         end else begin
            col_rem_ff <= col_rem_ff - CW_W'(1);
            src_col_ff <= flip_ff ? (src_col_ff - CW_W'(1)) : (src_col_ff + CW_W'(1));
            pix_ff     <= pix_ff + 20'd1;
         end
      end
   end

   // read stage
   logic       a_valid_ff, a_last_ff, a_blank_ff, a_mask_ff;
   logic [7:0] a_mcol_ff;
   logic [1:0] a_status_ff;
   logic [19:0] a_addr_ff;
   logic       out_free, a_issue;

   logic       rsp_valid_ff, rsp_last_ff, rsp_we_ff;
   logic [7:0] rsp_color_ff;
   logic [1:0] rsp_status_ff;
   logic [19:0] rsp_addr_ff;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign a_issue  = cmd.issue_pixel || cmd.issue_blank;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_issue) begin
         a_valid_ff <= 1'b1;
      end else if (out_free) begin
         a_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (a_issue) begin
         a_blank_ff  <= cmd.issue_blank;
         a_last_ff   <= cmd.issue_blank || (last_col && row_rem_ff == CH_W'(1));
         a_mask_ff   <= mask_ff;
         a_mcol_ff   <= mcol_ff;
         a_status_ff <= cmd.issue_blank ? 2'd0 : status_ff;
         a_addr_ff   <= cmd.issue_blank ? 20'd0 : pix_ff;
      end
   end

   // output stage
   logic src_we;

   assign src_we = !a_blank_ff && (rd_data_ff != 8'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_valid_ff && out_free) begin
         rsp_addr_ff   <= a_addr_ff;
         rsp_we_ff     <= src_we;
         rsp_color_ff  <= src_we ? (a_mask_ff ? a_mcol_ff : rd_data_ff) : 8'd0;
         rsp_status_ff <= a_status_ff;
         rsp_last_ff   <= a_last_ff;
      end
   end

   assign sts.empty    = empty_ff;
   assign sts.a_ready  = !a_valid_ff || out_free;
   assign sts.last_pix = last_col && (row_rem_ff == CH_W'(1));

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {1'b0, rsp_status_ff, rsp_we_ff, rsp_color_ff, rsp_addr_ff};

   `CSB_ASSERT_IMP(a_issue_into_free_stage, a_issue, (!a_valid_ff || out_free), "read stage overrun")
   `CSB_ASSERT_NXT(a_moves_to_output, (a_valid_ff && out_free), rsp_valid_ff, "read stage lost")
   `CSB_ASSERT_IMP(walk_in_range, cmd.issue_pixel, (col_rem_ff != '0 && row_rem_ff != '0), "walk overrun")
   `CSB_ASSERT_IMP(outside_is_blank_last, (rsp_valid_ff && rsp_status_ff == 2'd0), (rsp_last_ff && !rsp_we_ff), "bad outside result")

endmodule

// ----- rtl/core/clipped_sprite_blitter.sv -----
// Top level of the clipped sprite blitter: controller plus datapath.
// Load transfer: no result. Draw: accept, offset, clip and address steps, then one
// visible pixel read per cycle from the store read port while the output is not
// stalled; a fully outside draw gives one blank result marked last. Each read passes
// the read stage, then the output stage. Synchronous active-high reset returns
// the controller to idle, empties the read and output stages, loads register defaults.
module clipped_sprite_blitter import csb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // pos_x, pos_y, cell_index, flip_horizontal, mask_mode, mask_color,
   // load_address, load_value
   input  logic [71:0] req_tdata,
   // kind
   input  logic [0:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // pixel_address, pixel_color, write_enable, clip_status, zero pad
   output logic [31:0] rsp_tdata,
   output logic        rsp_tlast
);

   cmd_type cmd;
   sts_type sts;

   csb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (req_tuser[0]),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   csb_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
